[hw/rtl/assert_macros.svh]
// Assertion helpers for the RTL. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/ilc_pkg.sv]
package ilc_pkg;

    // Line length limit; lines of this length or more are invalid.
    localparam int ILC_MAX_LINE  = 1024;
    // Depths of the character request queue and of the result queue.
    localparam int ILC_CMD_DEPTH = 2;
    localparam int ILC_RES_DEPTH = 2;

    // Character classes handed from the front to the back.
    typedef logic [2:0] t_class;
    localparam t_class CL_OTHER  = 3'd0;
    localparam t_class CL_BLANK  = 3'd1;
    localparam t_class CL_LBRACK = 3'd2;
    localparam t_class CL_RBRACK = 3'd3;
    localparam t_class CL_EQ     = 3'd4;
    localparam t_class CL_TAG    = 3'd5;
    localparam t_class CL_END    = 3'd6;

    // Character codes of interest.
    localparam logic [15:0] CH_LBRACK = 16'h005B;
    localparam logic [15:0] CH_RBRACK = 16'h005D;
    localparam logic [15:0] CH_EQ     = 16'h003D;
    localparam logic [15:0] CH_HASH   = 16'h0023;
    localparam logic [15:0] CH_SEMI   = 16'h003B;
    localparam logic [15:0] CH_SPACE  = 16'h0020;
    localparam logic [15:0] CH_TAB    = 16'h0009;
    localparam logic [15:0] CH_CR     = 16'h000D;

    // Line types.
    localparam logic [2:0] T_INVALID = 3'd0;
    localparam logic [2:0] T_EMPTY   = 3'd1;
    localparam logic [2:0] T_SECT    = 3'd2;
    localparam logic [2:0] T_KEYVAL  = 3'd3;
    localparam logic [2:0] T_COMMENT = 3'd4;

    // Head of the character queue as seen by the back.
    typedef struct packed {
        logic   empty;
        t_class cls;
    } t_cmd_head;

    // One result of a finished line.
    typedef struct packed {
        logic [2:0] line_type;
        logic [9:0] name_start;
        logic [9:0] name_len;
        logic [9:0] value_start;
        logic [9:0] value_len;
        logic [9:0] comment_start;
        logic [9:0] comment_len;
    } t_result;

    // Reduce a character request to the class that the parser needs.
    function automatic t_class ilc_classify(input logic [15:0] ch, input logic line_end);
        t_class cls;
        if (line_end) begin
            cls = CL_END;
        end else if (ch inside {[CH_TAB:CH_CR], CH_SPACE}) begin
            cls = CL_BLANK;
        end else if (ch == CH_LBRACK) begin
            cls = CL_LBRACK;
        end else if (ch == CH_RBRACK) begin
            cls = CL_RBRACK;
        end else if (ch == CH_EQ) begin
            cls = CL_EQ;
        end else if (ch inside {CH_HASH, CH_SEMI}) begin
            cls = CL_TAG;
        end else begin
            cls = CL_OTHER;
        end
        return cls;
    endfunction

endpackage

[hw/rtl/ilc_fifo.sv]
module ilc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and occupancy updates, with wrap at the queue depth.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/ilc_front.sv]
module ilc_front
    import ilc_pkg::*;
#(
    parameter int CMD_DEPTH = ILC_CMD_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_ch,
    input  logic        i_line_end,
    output t_cmd_head   o_head,
    input  logic        i_pop
);

    t_class in_cls;
    t_class head_cls;
    logic   head_empty;

    // Each request is reduced to its class on the way into the queue.
    assign in_cls = ilc_classify(i_ch, i_line_end);

    ilc_fifo #(
        .WIDTH ($bits(t_class)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_cls),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_data  (head_cls),
        .o_empty (head_empty)
    );

    assign o_head.empty = head_empty;
    assign o_head.cls   = head_cls;

endmodule

[hw/rtl/ilc_back.sv]
module ilc_back
    import ilc_pkg::*;
#(
    parameter int MAX_LINE  = ILC_MAX_LINE,
    parameter int RES_DEPTH = ILC_RES_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_head i_head,
    output logic      o_pop,
    input  logic      pop,
    output logic      empty,
    output t_result   o_result
);

    localparam int POS_W = $clog2(MAX_LINE + 1);

    // Parser phases.
    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_COMMENT    = 3'd1;
    localparam logic [2:0] PH_SECT_OPEN  = 3'd2;
    localparam logic [2:0] PH_SECT_NAME  = 3'd3;
    localparam logic [2:0] PH_AFTER_SECT = 3'd4;
    localparam logic [2:0] PH_KEY_NAME   = 3'd5;
    localparam logic [2:0] PH_AFTER_EQ   = 3'd6;
    localparam logic [2:0] PH_VALUE      = 3'd7;

    logic [2:0]       r_phase, n_phase;
    logic [2:0]       r_pending, n_pending;
    logic             r_fixed, n_fixed;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [9:0]       r_begin, n_begin;
    logic [9:0]       r_last, n_last;
    logic [9:0]       r_name_start, n_name_start;
    logic [9:0]       r_name_len, n_name_len;
    logic [9:0]       r_val_start, n_val_start;
    logic [9:0]       r_val_len, n_val_len;

    logic [9:0] pos10;
    logic [9:0] span_len;
    logic       res_full;
    logic       res_push;
    t_result    res_data;
    logic       is_blank, is_tag;

    assign pos10    = 10'(r_pos);
    assign span_len = r_last - r_begin + 10'd1;
    assign is_blank = (i_head.cls == CL_BLANK);
    assign is_tag   = (i_head.cls == CL_TAG);

    // Per-character state transition and line completion.
    always_comb begin
        n_phase      = r_phase;
        n_pending    = r_pending;
        n_fixed      = r_fixed;
        n_pos        = r_pos;
        n_begin      = r_begin;
        n_last       = r_last;
        n_name_start = r_name_start;
        n_name_len   = r_name_len;
        n_val_start  = r_val_start;
        n_val_len    = r_val_len;
        o_pop        = 1'b0;
        res_push     = 1'b0;
        res_data     = '0;

        if (!i_head.empty) begin
            if (i_head.cls == CL_END) begin
                if (!res_full) begin
                    o_pop    = 1'b1;
                    res_push = 1'b1;
                    res_data.name_start  = r_name_start;
                    res_data.name_len    = r_name_len;
                    res_data.value_start = r_val_start;
                    res_data.value_len   = r_val_len;
                    case (r_phase)
                        PH_START: begin
                            res_data.line_type = T_EMPTY;
                        end
                        PH_COMMENT: begin
                            res_data.line_type     = r_pending;
                            res_data.comment_start = r_begin;
                            res_data.comment_len   = pos10 - r_begin;
                        end
                        PH_AFTER_SECT: begin
                            res_data.line_type = r_pending;
                        end
                        PH_AFTER_EQ: begin
                            res_data.line_type = T_KEYVAL;
                        end
                        PH_VALUE: begin
                            res_data.line_type   = T_KEYVAL;
                            res_data.value_start = r_begin;
                            res_data.value_len   = span_len;
                        end
                        default: begin
                            res_data.line_type = T_INVALID;
                        end
                    endcase
                    if (r_fixed || (r_pos >= POS_W'(MAX_LINE))) begin
                        res_data.line_type = T_INVALID;
                    end
                    // Invalid and empty lines carry no spans.
                    if (res_data.line_type == T_INVALID || res_data.line_type == T_EMPTY) begin
                        res_data = '0;
                        res_data.line_type = (r_fixed || (r_pos >= POS_W'(MAX_LINE)))
                                             ? T_INVALID
                                             : ((r_phase == PH_START) ? T_EMPTY : T_INVALID);
                    end
                    // Every per-line item returns to its start value.
                    n_phase      = PH_START;
                    n_pending    = T_COMMENT;
                    n_fixed      = 1'b0;
                    n_pos        = '0;
                    n_begin      = '0;
                    n_last       = '0;
                    n_name_start = '0;
                    n_name_len   = '0;
                    n_val_start  = '0;
                    n_val_len    = '0;
                end
            end else begin
                o_pop = 1'b1;
                if (r_pos < POS_W'(MAX_LINE)) begin
                    n_pos = r_pos + 1'b1;
                    if (!r_fixed) begin
                        case (r_phase)
                            PH_START: begin
                                if (i_head.cls == CL_LBRACK) begin
                                    n_phase = PH_SECT_OPEN;
                                end else if (is_tag) begin
                                    n_begin = pos10;
                                    n_last  = pos10;
                                    n_phase = PH_COMMENT;
                                end else if (!is_blank) begin
                                    n_begin = pos10;
                                    n_last  = pos10;
                                    n_phase = PH_KEY_NAME;
                                end
                            end
                            PH_SECT_OPEN: begin
                                if (i_head.cls == CL_LBRACK || i_head.cls == CL_RBRACK) begin
                                    n_fixed = 1'b1;
                                end else if (!is_blank) begin
                                    n_begin = pos10;
                                    n_last  = pos10;
                                    n_phase = PH_SECT_NAME;
                                end
                            end
                            PH_SECT_NAME: begin
                                if (i_head.cls == CL_RBRACK) begin
                                    n_name_start = r_begin;
                                    n_name_len   = span_len;
                                    n_pending    = T_SECT;
                                    n_phase      = PH_AFTER_SECT;
                                end else if (i_head.cls == CL_LBRACK) begin
                                    n_fixed = 1'b1;
                                end else if (!is_blank) begin
                                    n_last = pos10;
                                end
                            end
                            PH_AFTER_SECT: begin
                                if (is_tag) begin
                                    n_begin = pos10;
                                    n_last  = pos10;
                                    n_phase = PH_COMMENT;
                                end
                            end
                            PH_KEY_NAME: begin
                                if (i_head.cls == CL_EQ) begin
                                    n_name_start = r_begin;
                                    n_name_len   = span_len;
                                    n_phase      = PH_AFTER_EQ;
                                end else if (!is_blank) begin
                                    n_last = pos10;
                                end
                            end
                            PH_AFTER_EQ: begin
                                if (is_tag) begin
                                    n_pending = T_KEYVAL;
                                    n_begin   = pos10;
                                    n_last    = pos10;
                                    n_phase   = PH_COMMENT;
                                end else if (!is_blank) begin
                                    n_begin = pos10;
                                    n_last  = pos10;
                                    n_phase = PH_VALUE;
                                end
                            end
                            PH_VALUE: begin
                                if (is_tag) begin
                                    n_val_start = r_begin;
                                    n_val_len   = span_len;
                                    n_pending   = T_KEYVAL;
                                    n_begin     = pos10;
                                    n_last      = pos10;
                                    n_phase     = PH_COMMENT;
                                end else if (!is_blank) begin
                                    n_last = pos10;
                                end
                            end
                            default: begin
                                // The comment runs to the end of the line.
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_pending    <= T_COMMENT;
            r_fixed      <= 1'b0;
            r_pos        <= '0;
            r_begin      <= '0;
            r_last       <= '0;
            r_name_start <= '0;
            r_name_len   <= '0;
            r_val_start  <= '0;
            r_val_len    <= '0;
        end else begin
            r_phase      <= n_phase;
            r_pending    <= n_pending;
            r_fixed      <= n_fixed;
            r_pos        <= n_pos;
            r_begin      <= n_begin;
            r_last       <= n_last;
            r_name_start <= n_name_start;
            r_name_len   <= n_name_len;
            r_val_start  <= n_val_start;
            r_val_len    <= n_val_len;
        end
    end

    // Results wait here so that parsing goes on while the consumer stalls.
    ilc_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_data),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty)
    );

endmodule

[hw/rtl/ini_line_classifier.sv]
// Throughput: one character request per cycle, sustained, set by the parser step in the
// back part; the input stalls only while the result queue is full.
// A line result is written into the result queue when the back takes the line's end
// request from the character queue; it takes it only while the result queue has room.
// Reset: synchronous, active low; empties both queues and returns the parser
// to the start of a line.
module ini_line_classifier
    import ilc_pkg::*;
#(
    parameter int MAX_LINE  = ILC_MAX_LINE,
    parameter int CMD_DEPTH = ILC_CMD_DEPTH,
    parameter int RES_DEPTH = ILC_RES_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_ch,
    input  logic        i_line_end,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_line_type,
    output logic [9:0]  o_name_start,
    output logic [9:0]  o_name_len,
    output logic [9:0]  o_value_start,
    output logic [9:0]  o_value_len,
    output logic [9:0]  o_comment_start,
    output logic [9:0]  o_comment_len
);

`include "assert_macros.svh"

    t_cmd_head cmd_head;
    logic      cmd_pop;
    t_result   result;
    logic      blank_line;
    logic      no_spans;
    logic      comment_line;
    logic      comment_ok;
    logic      sect_line;
    logic      sect_ok;
    logic      end_taken;

    // Front: classifies characters and queues them.
    ilc_front #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_ch       (i_ch),
        .i_line_end (i_line_end),
        .o_head     (cmd_head),
        .i_pop      (cmd_pop)
    );

    // Back: runs the line parser and queues the results.
    ilc_back #(
        .MAX_LINE  (MAX_LINE),
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (cmd_head),
        .o_pop    (cmd_pop),
        .pop      (pop),
        .empty    (empty),
        .o_result (result)
    );

    assign o_line_type     = result.line_type;
    assign o_name_start    = result.name_start;
    assign o_name_len      = result.name_len;
    assign o_value_start   = result.value_start;
    assign o_value_len     = result.value_len;
    assign o_comment_start = result.comment_start;
    assign o_comment_len   = result.comment_len;

    // Terms used by the checks below.
    assign blank_line   = !empty && ((o_line_type == T_INVALID) || (o_line_type == T_EMPTY));
    assign no_spans     = (o_name_start == '0) && (o_name_len == '0)
                          && (o_value_start == '0) && (o_value_len == '0)
                          && (o_comment_start == '0) && (o_comment_len == '0);
    assign comment_line = !empty && (o_line_type == T_COMMENT);
    assign comment_ok   = (o_comment_len != '0) && (o_name_len == '0);
    assign sect_line    = !empty && (o_line_type == T_SECT);
    assign sect_ok      = (o_name_len != '0) && (o_value_len == '0);
    assign end_taken    = cmd_pop && (cmd_head.cls == CL_END);

    // Invalid and empty lines must carry no spans at all.
    `ASSERT_IMPLIES(a_no_span_on_blank, i_clk, i_rst_n, blank_line, no_spans)

    // A comment-only line always has a comment of at least its tag.
    `ASSERT_IMPLIES(a_comment_len, i_clk, i_rst_n, comment_line, comment_ok)

    // A section always has a non-empty name.
    `ASSERT_IMPLIES(a_sect_name, i_clk, i_rst_n, sect_line, sect_ok)

    // The back never drains the character queue when it is empty.
    `ASSERT_IMPLIES(a_pop_empty, i_clk, i_rst_n, cmd_head.empty, !cmd_pop)

    // A finished line is waiting in the result queue on the next cycle.
    `ASSERT_NEXT(a_res_written, i_clk, i_rst_n, end_taken, !empty)

endmodule

[tb/tb_ini_line_classifier.sv]
module tb_ini_line_classifier;
    import ilc_pkg::*;

    // Parser phases of the predictor.
    typedef enum logic [3:0] {
        PH_START,
        PH_COMMENT,
        PH_SECT_OPEN,
        PH_SECT_NAME,
        PH_AFTER_SECT,
        PH_KEY_NAME,
        PH_AFTER_EQ,
        PH_VALUE
    } t_phase;

    localparam int RUN_LIMIT    = 400000;
    localparam int RUN_ITEMS    = 500;
    localparam int HOLD_OFF     = 400;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [15:0] CH_ZERO  = 16'h0000;
    localparam logic [15:0] CH_UNDER = 16'h005F;
    localparam logic [15:0] CH_LOW_A = 16'h0061;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [15:0] i_ch;
    logic        i_line_end;
    logic        empty;
    logic        pop;
    logic [2:0]  o_line_type;
    logic [9:0]  o_name_start;
    logic [9:0]  o_name_len;
    logic [9:0]  o_value_start;
    logic [9:0]  o_value_len;
    logic [9:0]  o_comment_start;
    logic [9:0]  o_comment_len;

    logic [15:0] line_buf[$];
    int          items_sent;
    bit          steady_tail;

    // Character classes used by both the predictor and the line builder.
    function automatic bit char_is_blank(logic [15:0] c);
        return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
    endfunction

    function automatic bit char_is_tag(logic [15:0] c);
        return c == CH_HASH || c == CH_SEMI;
    endfunction

    function automatic bit char_is_special(logic [15:0] c);
        return char_is_blank(c) || char_is_tag(c) || c == CH_LBRACK || c == CH_RBRACK
            || c == CH_EQ;
    endfunction

    // Line parser predictor and the queue of line results it expects.
    class line_scoreboard;
        t_result    expected_q[$];
        int         errors;
        t_phase     phase;
        logic [2:0] pending_kind;
        logic       verdict_fixed;
        int         position;
        logic [9:0] span_begin;
        logic [9:0] span_last;
        logic [9:0] name_start;
        logic [9:0] name_len;
        logic [9:0] value_start;
        logic [9:0] value_len;
        logic [9:0] comment_start;
        logic [9:0] comment_len;

        function new();
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase         = PH_START;
            pending_kind  = T_COMMENT;
            verdict_fixed = 1'b0;
            position      = 0;
            span_begin    = '0;
            span_last     = '0;
            name_start    = '0;
            name_len      = '0;
            value_start   = '0;
            value_len     = '0;
            comment_start = '0;
            comment_len   = '0;
        endfunction

        function void open_span(logic [9:0] p, t_phase next_phase);
            span_begin = p;
            span_last  = p;
            phase      = next_phase;
        endfunction

        // One character step of the parser.
        function void take_char(logic [15:0] c, logic [9:0] p);
            bit blank;
            blank = char_is_blank(c);
            case (phase)
                PH_START: begin
                    if (!blank) begin
                        if (c == CH_LBRACK) phase = PH_SECT_OPEN;
                        else if (char_is_tag(c)) open_span(p, PH_COMMENT);
                        else open_span(p, PH_KEY_NAME);
                    end
                end
                PH_SECT_OPEN: begin
                    if (!blank) begin
                        if (c == CH_LBRACK || c == CH_RBRACK) verdict_fixed = 1'b1;
                        else open_span(p, PH_SECT_NAME);
                    end
                end
                PH_SECT_NAME: begin
                    if (c == CH_RBRACK) begin
                        name_start   = span_begin;
                        name_len     = span_last - span_begin + 10'd1;
                        pending_kind = T_SECT;
                        phase        = PH_AFTER_SECT;
                    end else if (c == CH_LBRACK) begin
                        verdict_fixed = 1'b1;
                    end else if (!blank) begin
                        span_last = p;
                    end
                end
                PH_AFTER_SECT: begin
                    if (char_is_tag(c)) open_span(p, PH_COMMENT);
                end
                PH_KEY_NAME: begin
                    if (c == CH_EQ) begin
                        name_start = span_begin;
                        name_len   = span_last - span_begin + 10'd1;
                        phase      = PH_AFTER_EQ;
                    end else if (!blank) begin
                        span_last = p;
                    end
                end
                PH_AFTER_EQ: begin
                    if (!blank) begin
                        if (char_is_tag(c)) begin
                            pending_kind = T_KEYVAL;
                            open_span(p, PH_COMMENT);
                        end else begin
                            open_span(p, PH_VALUE);
                        end
                    end
                end
                PH_VALUE: begin
                    if (!blank) begin
                        if (char_is_tag(c)) begin
                            value_start  = span_begin;
                            value_len    = span_last - span_begin + 10'd1;
                            pending_kind = T_KEYVAL;
                            open_span(p, PH_COMMENT);
                        end else begin
                            span_last = p;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted request; an end request closes the line.
        function void note_request(logic [15:0] ch, logic line_end);
            t_result    r;
            logic [2:0] kind;
            if (!line_end) begin
                if (position < ILC_MAX_LINE) begin
                    if (!verdict_fixed) take_char(ch, position[9:0]);
                    position++;
                end
            end else begin
                kind = T_INVALID;
                if (position < ILC_MAX_LINE && !verdict_fixed) begin
                    case (phase)
                        PH_START: kind = T_EMPTY;
                        PH_COMMENT: begin
                            comment_start = span_begin;
                            comment_len   = position[9:0] - span_begin;
                            kind          = pending_kind;
                        end
                        PH_AFTER_SECT: kind = pending_kind;
                        PH_AFTER_EQ: kind = T_KEYVAL;
                        PH_VALUE: begin
                            value_start = span_begin;
                            value_len   = span_last - span_begin + 10'd1;
                            kind        = T_KEYVAL;
                        end
                        default: kind = T_INVALID;
                    endcase
                end
                r = '0;
                r.line_type = kind;
                if (kind != T_INVALID && kind != T_EMPTY) begin
                    r.name_start    = name_start;
                    r.name_len      = name_len;
                    r.value_start   = value_start;
                    r.value_len     = value_len;
                    r.comment_start = comment_start;
                    r.comment_len   = comment_len;
                end
                expected_q.push_back(r);
                clear_line();
            end
        endfunction

        function void compare_field(string field, logic [9:0] want, logic [9:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        // Called for every accepted result.
        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no line waiting, expected none, actual type %0d",
                         $time, got.line_type);
                errors++;
            end else begin
                want = expected_q.pop_front();
                compare_field("line_type", 10'(want.line_type), 10'(got.line_type));
                compare_field("name_start", want.name_start, got.name_start);
                compare_field("name_len", want.name_len, got.name_len);
                compare_field("value_start", want.value_start, got.value_start);
                compare_field("value_len", want.value_len, got.value_len);
                compare_field("comment_start", want.comment_start, got.comment_start);
                compare_field("comment_len", want.comment_len, got.comment_len);
            end
        endfunction
    endclass

    line_scoreboard sb;

    ini_line_classifier u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_ch            (i_ch),
        .i_line_end      (i_line_end),
        .empty           (empty),
        .pop             (pop),
        .o_line_type     (o_line_type),
        .o_name_start    (o_name_start),
        .o_name_len      (o_name_len),
        .o_value_start   (o_value_start),
        .o_value_len     (o_value_len),
        .o_comment_start (o_comment_start),
        .o_comment_len   (o_comment_len)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Line building helpers.
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back({8'h00, s[i]});
    endfunction

    function automatic void add_blanks(int n);
        logic [15:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) c = CH_TAB + 16'($urandom_range(0, 4));
            else c = CH_SPACE;
            line_buf.push_back(c);
        end
    endfunction

    function automatic logic [15:0] word_char();
        logic [15:0] c;
        case ($urandom_range(0, 7))
            0: c = 16'($urandom_range(0, 65535));
            1: c = CH_ZERO;
            2: c = 16'hFFFF;
            default: c = CH_LOW_A + 16'($urandom_range(0, 25));
        endcase
        if (char_is_special(c)) c = CH_UNDER;
        return c;
    endfunction

    function automatic logic [15:0] special_char();
        logic [15:0] c;
        case ($urandom_range(0, 8))
            0: c = CH_LBRACK;
            1: c = CH_RBRACK;
            2: c = CH_EQ;
            3: c = CH_HASH;
            4: c = CH_SEMI;
            5: c = CH_SPACE;
            6: c = CH_TAB + 16'($urandom_range(0, 4));
            default: c = 16'($urandom_range(0, 65535));
        endcase
        return c;
    endfunction

    // Words separated by blanks; single-character words are common.
    function automatic void add_words(int count);
        for (int w = 0; w < count; w++) begin
            if (w > 0) add_blanks($urandom_range(1, 2));
            for (int i = $urandom_range(1, 4); i > 0; i--) line_buf.push_back(word_char());
        end
    endfunction

    function automatic void add_comment();
        line_buf.push_back($urandom_range(0, 1) ? CH_HASH : CH_SEMI);
        for (int i = $urandom_range(0, 6); i > 0; i--) begin
            line_buf.push_back(16'($urandom_range(0, 65535)));
        end
    endfunction

    function automatic void build_key_value();
        add_blanks($urandom_range(0, 2));
        add_words($urandom_range(1, 2));
        add_blanks($urandom_range(0, 2));
        line_buf.push_back(CH_EQ);
        add_blanks($urandom_range(0, 2));
        if ($urandom_range(0, 4) != 0) add_words($urandom_range(1, 3));
        add_blanks($urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0) add_comment();
    endfunction

    // One random line: mostly well formed, the rest noise or broken.
    function automatic void build_random_line();
        int kind;
        kind = $urandom_range(0, 19);
        if (kind <= 1) begin
            add_blanks($urandom_range(0, 4));
        end else if (kind <= 5) begin
            add_blanks($urandom_range(0, 2));
            line_buf.push_back(CH_LBRACK);
            add_blanks($urandom_range(0, 2));
            add_words($urandom_range(1, 2));
            add_blanks($urandom_range(0, 2));
            line_buf.push_back(CH_RBRACK);
            if ($urandom_range(0, 3) == 0) add_words(1);
            if ($urandom_range(0, 2) == 0) add_comment();
        end else if (kind <= 12) begin
            build_key_value();
        end else if (kind <= 14) begin
            add_blanks($urandom_range(0, 2));
            add_comment();
        end else if (kind <= 17) begin
            for (int i = $urandom_range(1, 12); i > 0; i--) begin
                if ($urandom_range(0, 1)) line_buf.push_back(special_char());
                else line_buf.push_back(word_char());
            end
        end else begin
            // A key-value line with one character replaced by a special one.
            build_key_value();
            line_buf[$urandom_range(0, line_buf.size() - 1)] = special_char();
        end
    endfunction

    // Offer one request and hold it until the block takes it.
    task automatic send_request(logic [15:0] ch, logic line_end, bit gappy);
        if (gappy && $urandom_range(0, 4) == 0) begin
            push = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        push       = 1'b1;
        i_ch       = ch;
        i_line_end = line_end;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_request(ch, line_end);
        @(negedge i_clk);
    endtask

    task automatic send_line();
        bit gappy;
        gappy = !steady_tail && ($urandom_range(0, 2) != 0);
        foreach (line_buf[i]) send_request(line_buf[i], 1'b0, gappy);
        send_request(16'($urandom_range(0, 65535)), 1'b1, gappy);
        items_sent += line_buf.size() + 1;
        line_buf.delete();
    endtask

    // Extremes and special cases on short lines.
    task automatic run_directed();
        string short_lines[$];
        short_lines = '{"", "[sect]", "  [ my sect ]  ; note", "[]", "[a[b]", "[abc",
                        "[ [x]", "key=value", " key name = some value  # c", "k=",
                        "k= ;c", "==v", "=v", "novalue", "# comment", ";", "k=a b",
                        "[s] junk = x"};
        foreach (short_lines[i]) begin
            add_text(short_lines[i]);
            send_line();
        end
        // Every blank code, all in one line.
        for (int c = int'(CH_TAB); c <= int'(CH_CR); c++) line_buf.push_back(16'(c));
        line_buf.push_back(CH_SPACE);
        send_line();
        // Code zero and wide characters are ordinary characters.
        line_buf = '{CH_ZERO, CH_EQ, 16'hFFFF, 16'h8000, 16'h000E, CH_SPACE, 16'h0008};
        send_line();
    endtask

    // Main sequence: reset, stimulus, drain and verdict.
    initial begin : main_seq
        sb          = new();
        steady_tail = 1'b0;
        items_sent  = 0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_ch        = '0;
        i_line_end  = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        while (items_sent < RUN_ITEMS) begin
            if (items_sent >= RUN_ITEMS * 4 / 5) steady_tail = 1'b1;
            build_random_line();
            send_line();
        end
        push = 1'b0;

        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** ini_line_classifier: PASSED **");
        end else begin
            if (sb.expected_q.size() != 0)
                $display("%0t: %0d line results never arrived", $time, sb.expected_q.size());
            $display("** ini_line_classifier: FAILED **");
        end
        $finish;
    end

    // Result side: a long hold-off first so the block fills, then random bursts.
    initial begin : drive_pop
        int hold;
        int idle_left;
        int stretch;
        bit gappy;
        pop       = 1'b0;
        idle_left = 0;
        stretch   = 0;
        gappy     = 1'b0;
        wait (i_rst_n === 1'b1);
        hold = 0;
        while (hold < HOLD_OFF) begin
            @(negedge i_clk);
            hold++;
        end
        forever begin
            if (stretch == 0) begin
                stretch = $urandom_range(20, 80);
                gappy   = ($urandom_range(0, 1) != 0);
            end
            stretch--;
            if (idle_left == 0 && gappy && !steady_tail && $urandom_range(0, 3) == 0)
                idle_left = $urandom_range(1, 7);
            if (idle_left > 0) begin
                pop = 1'b0;
                idle_left--;
            end else begin
                pop = 1'b1;
            end
            @(negedge i_clk);
        end
    end

    // Check every result taken from the block.
    always @(posedge i_clk) begin : collect_results
        t_result got;
        if (i_rst_n && pop && !empty) begin
            got.line_type     = o_line_type;
            got.name_start    = o_name_start;
            got.name_len      = o_name_len;
            got.value_start   = o_value_start;
            got.value_len     = o_value_len;
            got.comment_start = o_comment_start;
            got.comment_len   = o_comment_len;
            sb.check_result(got);
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
        $display("** ini_line_classifier: FAILED **");
        $finish;
    end

endmodule
